[rtl/qpr_pkg.sv]
package qpr_pkg;

    // component format
    localparam int FRAC_BITS  = 14;
    localparam int COMP_WIDTH = 16;

    // exact products and their four-term sums
    localparam int PROD_W = 2 * COMP_WIDTH + 1;
    localparam int SUM_W  = PROD_W + 2;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // number of back pipeline stages
    localparam int BACK_STAGES = 4;

    typedef logic signed [COMP_WIDTH-1:0] comp_t;
    typedef logic signed [COMP_WIDTH:0]   wcomp_t;

    // component order x, y, z, w
    typedef comp_t  quat_t  [4];
    typedef wcomp_t wquat_t [4];

    typedef enum logic
    {
        OP_PRODUCT,
        OP_ROTATE
    } op_t;

    typedef struct
    {
        op_t   op;
        quat_t q;
        quat_t p;
    } item_t;

endpackage

[rtl/quaternion_product_rotate_unit.sv]
// channel | handshake            | fields
// --------+----------------------+------------------------------------------
// input   | in_valid / in_ready   | mode, q_x, q_y, q_z, q_w, p_x, p_y, p_z, p_w
// output  | out_valid / out_ready | r_x, r_y, r_z, r_w, clipped
//
// one beat per cycle sustained while the output is not stalled; an accepted
// beat passes through the two-entry queue and then the four product pipeline
// stages before output valid.
// both product passes run on every beat; the rotate result uses the second.
// reset clears queue pointers, queue fill count and stage valids only.
// output stall freezes the pipeline; the queue keeps taking beats until full.
module quaternion_product_rotate_unit
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   mode,
    input  qpr_pkg::comp_t         q_x,
    input  qpr_pkg::comp_t         q_y,
    input  qpr_pkg::comp_t         q_z,
    input  qpr_pkg::comp_t         q_w,
    input  qpr_pkg::comp_t         p_x,
    input  qpr_pkg::comp_t         p_y,
    input  qpr_pkg::comp_t         p_z,
    input  qpr_pkg::comp_t         p_w,
    output logic                   out_valid,
    input  logic                   out_ready,
    output qpr_pkg::comp_t         r_x,
    output qpr_pkg::comp_t         r_y,
    output qpr_pkg::comp_t         r_z,
    output qpr_pkg::comp_t         r_w,
    output logic                   clipped
);
    import qpr_pkg::*;

    quat_t in_q;
    quat_t in_p;
    quat_t out_r;
    item_t item;
    logic  item_valid;
    logic  pop;

    // gather component ports
    always_comb
    begin
        in_q[0] = q_x;
        in_q[1] = q_y;
        in_q[2] = q_z;
        in_q[3] = q_w;
        in_p[0] = p_x;
        in_p[1] = p_y;
        in_p[2] = p_z;
        in_p[3] = p_w;
    end

    // accept and queue
    qpr_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_mode    (mode),
        .in_q       (in_q),
        .in_p       (in_p),
        .item_valid (item_valid),
        .item       (item),
        .pop        (pop)
    );

    // product pipeline
    qpr_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_r      (out_r),
        .out_clip   (clipped)
    );

    assign r_x = out_r[0];
    assign r_y = out_r[1];
    assign r_z = out_r[2];
    assign r_w = out_r[3];

    // a stalled output must hold the queue
    a_stall_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !pop)
        else $error("queue popped while output stalled");

    // an accepted beat is waiting in the queue next cycle
    a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> item_valid)
        else $error("accepted beat not visible in queue");

    // input back-pressure only when the queue holds beats
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> item_valid)
        else $error("input stalled with empty queue");

    // nothing pops from an empty queue
    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> item_valid)
        else $error("pop from empty queue");

endmodule

[rtl/qpr_front.sv]
module qpr_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           in_mode,
    input  qpr_pkg::quat_t in_q,
    input  qpr_pkg::quat_t in_p,
    output logic           item_valid,
    output qpr_pkg::item_t item,
    input  logic           pop
);
    import qpr_pkg::*;

    item_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               push;
    item_t              new_item;

    // classify the incoming beat
    always_comb
    begin
        new_item.op = in_mode ? OP_ROTATE : OP_PRODUCT;
        new_item.q  = in_q;
        new_item.p  = in_p;
    end

    assign in_ready   = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push       = in_valid && in_ready;
    assign item_valid = (count_reg != '0);
    assign item       = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

[rtl/qpr_ham.sv]
module qpr_ham
(
    input  logic            clk,
    input  logic            en,
    input  qpr_pkg::quat_t  a,
    input  qpr_pkg::wquat_t b,
    output qpr_pkg::quat_t  r,
    output logic            clip
);
    import qpr_pkg::*;

    localparam longint MAX_L = (64'sd1 <<< (COMP_WIDTH - 1)) - 64'sd1;
    localparam logic signed [SUM_W-1:0] MAX_V = SUM_W'(MAX_L);
    localparam logic signed [SUM_W-1:0] MIN_V = SUM_W'(-MAX_L - 64'sd1);
    localparam logic signed [SUM_W-1:0] HALF  = SUM_W'(64'sd1 <<< (FRAC_BITS - 1));

    logic signed [PROD_W-1:0] prod_reg [4][4];
    logic signed [SUM_W-1:0]  sum      [4];
    logic signed [SUM_W-1:0]  scaled   [4];
    comp_t                    res      [4];
    logic [3:0]               sat;
    quat_t                    r_reg;
    logic                     clip_reg;

    // stage 1: all sixteen cross products, prod_reg[i][j] = a[i] * b[j]
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    prod_reg[i][j] <= PROD_W'(a[i]) * PROD_W'(b[j]);
                end
            end
        end
    end

    // hamilton sums
    always_comb
    begin
        sum[0] = SUM_W'(prod_reg[0][3]) + SUM_W'(prod_reg[3][0])
               + SUM_W'(prod_reg[1][2]) - SUM_W'(prod_reg[2][1]);
        sum[1] = SUM_W'(prod_reg[1][3]) + SUM_W'(prod_reg[3][1])
               + SUM_W'(prod_reg[2][0]) - SUM_W'(prod_reg[0][2]);
        sum[2] = SUM_W'(prod_reg[2][3]) + SUM_W'(prod_reg[3][2])
               + SUM_W'(prod_reg[0][1]) - SUM_W'(prod_reg[1][0]);
        sum[3] = SUM_W'(prod_reg[3][3]) - SUM_W'(prod_reg[0][0])
               - SUM_W'(prod_reg[1][1]) - SUM_W'(prod_reg[2][2]);
    end

    // round half up, then saturate
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            scaled[i] = (sum[i] + HALF) >>> FRAC_BITS;
            if (scaled[i] > MAX_V)
            begin
                res[i] = comp_t'(MAX_V);
                sat[i] = 1'b1;
            end
            else if (scaled[i] < MIN_V)
            begin
                res[i] = comp_t'(MIN_V);
                sat[i] = 1'b1;
            end
            else
            begin
                res[i] = comp_t'(scaled[i]);
                sat[i] = 1'b0;
            end
        end
    end

    // stage 2: rounded result
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg    <= res;
            clip_reg <= |sat;
        end
    end

    assign r    = r_reg;
    assign clip = clip_reg;

endmodule

[rtl/qpr_back.sv]
module qpr_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  qpr_pkg::item_t item,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output qpr_pkg::quat_t out_r,
    output logic           out_clip
);
    import qpr_pkg::*;

    logic [BACK_STAGES-1:0] valid_reg;
    logic [BACK_STAGES-1:0] valid_next;
    op_t                    op_reg [BACK_STAGES];
    quat_t                  q_s1_reg;
    quat_t                  q_s2_reg;
    quat_t                  t_s3_reg;
    quat_t                  t_s4_reg;
    logic                   clip_s3_reg;
    logic                   clip_s4_reg;
    logic                   en;
    wquat_t                 p_wide;
    wquat_t                 q_conj;
    quat_t                  t;
    logic                   t_clip;
    quat_t                  rot;
    logic                   rot_clip;

    // whole pipeline moves when the last stage is free
    assign en  = !valid_reg[BACK_STAGES-1] || out_ready;
    assign pop = en && item_valid;

    // operand widening and conjugate of q
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            p_wide[i] = {item.p[i][COMP_WIDTH-1], item.p[i]};
        end
        for (int i = 0; i < 3; i++)
        begin
            q_conj[i] = -{q_s2_reg[i][COMP_WIDTH-1], q_s2_reg[i]};
        end
        q_conj[3] = {q_s2_reg[3][COMP_WIDTH-1], q_s2_reg[3]};
    end

    // first product q*p
    qpr_ham u_ham_qp
    (
        .clk  (clk),
        .en   (en),
        .a    (item.q),
        .b    (p_wide),
        .r    (t),
        .clip (t_clip)
    );

    // second product t*conj(q)
    qpr_ham u_ham_rot
    (
        .clk  (clk),
        .en   (en),
        .a    (t),
        .b    (q_conj),
        .r    (rot),
        .clip (rot_clip)
    );

    // stage valids
    always_comb
    begin
        valid_next = valid_reg;
        if (en)
        begin
            valid_next = {valid_reg[BACK_STAGES-2:0], item_valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // side data that travels alongside the product units
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg[0] <= item.op;
            for (int s = 1; s < BACK_STAGES; s++)
            begin
                op_reg[s] <= op_reg[s-1];
            end
            q_s1_reg    <= item.q;
            q_s2_reg    <= q_s1_reg;
            t_s3_reg    <= t;
            t_s4_reg    <= t_s3_reg;
            clip_s3_reg <= t_clip;
            clip_s4_reg <= clip_s3_reg;
        end
    end

    // result select
    always_comb
    begin
        out_valid = valid_reg[BACK_STAGES-1];
        unique case (op_reg[BACK_STAGES-1])
            OP_ROTATE:
            begin
                out_r    = rot;
                out_clip = clip_s4_reg || rot_clip;
            end
            default:
            begin
                out_r    = t_s4_reg;
                out_clip = clip_s4_reg;
            end
        endcase
    end

endmodule

[verif/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import qpr_pkg::*;

    localparam int     IDLE_PCT    = 15;
    localparam int     TAIL_CYCLES = 20;
    localparam int     RAND_ITEMS  = 1600;
    localparam int     CALM_START  = 700;
    localparam int     CALM_END    = 1300;
    localparam longint SAT_MAX     = (longint'(1) <<< (COMP_WIDTH - 1)) - 1;
    localparam longint SAT_MIN     = -SAT_MAX - 1;
    localparam longint HALF_LSB    = longint'(1) <<< (FRAC_BITS - 1);

    typedef longint wide_quat_t [4];

    typedef struct
    {
        quat_t r;
        logic  clip;
    } quat_result_t;

    // dut ports
    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  mode      = 1'b0;
    comp_t q_x       = '0;
    comp_t q_y       = '0;
    comp_t q_z       = '0;
    comp_t q_w       = '0;
    comp_t p_x       = '0;
    comp_t p_y       = '0;
    comp_t p_z       = '0;
    comp_t p_w       = '0;
    logic  out_ready = 1'b0;
    logic  in_ready;
    logic  out_valid;
    comp_t r_x;
    comp_t r_y;
    comp_t r_z;
    comp_t r_w;
    logic  clipped;

    // testbench state
    item_t        operand_queue [$];
    quat_result_t expected_quats [$];
    int           drain_marks [$];
    item_t        cur_beat;
    int           beats_sent   = 0;
    int           n_products   = 0;
    int           n_rotations  = 0;
    int           n_saturated  = 0;
    int           errors       = 0;
    int           cycle_no     = 0;
    string        axis [4]     = '{"x", "y", "z", "w"};

    quaternion_product_rotate_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .q_x       (q_x),
        .q_y       (q_y),
        .q_z       (q_z),
        .q_w       (q_w),
        .p_x       (p_x),
        .p_y       (p_y),
        .p_z       (p_z),
        .p_w       (p_w),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .r_x       (r_x),
        .r_y       (r_y),
        .r_z       (r_z),
        .r_w       (r_w),
        .clipped   (clipped)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
    end

    // round half up towards plus infinity, then clamp to the component range
    function automatic longint round_sat(input longint acc, inout bit clip);
        longint r;
        r = (acc + HALF_LSB) >>> FRAC_BITS;
        if (r > SAT_MAX)
        begin
            clip = 1'b1;
            r    = SAT_MAX;
        end
        if (r < SAT_MIN)
        begin
            clip = 1'b1;
            r    = SAT_MIN;
        end
        return r;
    endfunction

    // a * b, each component rounded and saturated on its own
    function automatic void hamilton_round(input wide_quat_t a, input wide_quat_t b,
                                           output wide_quat_t res, inout bit clip);
        res[0] = round_sat(a[0] * b[3] + a[3] * b[0] + a[1] * b[2] - a[2] * b[1], clip);
        res[1] = round_sat(a[1] * b[3] + a[3] * b[1] + a[2] * b[0] - a[0] * b[2], clip);
        res[2] = round_sat(a[2] * b[3] + a[3] * b[2] + a[0] * b[1] - a[1] * b[0], clip);
        res[3] = round_sat(a[3] * b[3] - a[0] * b[0] - a[1] * b[1] - a[2] * b[2], clip);
    endfunction

    // product q*p, or rotation q*p*conj(q) built on the rounded product
    function automatic quat_result_t predict_quat(input item_t it);
        wide_quat_t   qa;
        wide_quat_t   pa;
        wide_quat_t   ta;
        wide_quat_t   ca;
        wide_quat_t   ra;
        quat_result_t res;
        bit           clip;
        int           i;
        clip = 1'b0;
        for (i = 0; i < 4; i++)
        begin
            qa[i] = longint'(it.q[i]);
            pa[i] = longint'(it.p[i]);
        end
        hamilton_round(qa, pa, ta, clip);
        if (it.op == OP_ROTATE)
        begin
            // conjugate is exact, so -(-2.0) stays +2.0
            ca[0] = -qa[0];
            ca[1] = -qa[1];
            ca[2] = -qa[2];
            ca[3] = qa[3];
            hamilton_round(ta, ca, ra, clip);
        end
        else
        begin
            ra = ta;
        end
        for (i = 0; i < 4; i++)
            res.r[i] = comp_t'(ra[i]);
        res.clip = clip;
        return res;
    endfunction

    function automatic comp_t pick_comp();
        int corners [10];
        int style;
        corners = '{-32768, -32767, -16384, -1, 0, 1, 8192, 16384, 32766, 32767};
        style   = $urandom_range(9);
        if (style <= 3)
            return comp_t'($urandom);
        else if (style <= 6)
            return comp_t'(int'($urandom_range(32768)) - 16384);
        else if (style <= 8)
            return comp_t'(corners[$urandom_range(9)]);
        else
            return comp_t'(int'($urandom_range(8)) - 4);
    endfunction

    task automatic push_item(input op_t op, input int qx, input int qy, input int qz,
                             input int qw, input int px, input int py, input int pz,
                             input int pw);
        item_t it;
        it.op   = op;
        it.q[0] = comp_t'(qx);
        it.q[1] = comp_t'(qy);
        it.q[2] = comp_t'(qz);
        it.q[3] = comp_t'(qw);
        it.p[0] = comp_t'(px);
        it.p[1] = comp_t'(py);
        it.p[2] = comp_t'(pz);
        it.p[3] = comp_t'(pw);
        operand_queue.push_back(it);
    endtask

    function automatic bit idle_allowed();
        return !(cycle_no >= CALM_START && cycle_no < CALM_END);
    endfunction

    // input driver: holds a beat until accepted, then predicts its result
    always @(posedge clk)
    begin
        item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                expected_quats.push_back(predict_quat(cur_beat));
                beats_sent++;
                if (cur_beat.op == OP_ROTATE)
                    n_rotations++;
                else
                    n_products++;
            end
            if (drain_marks.size() != 0 && drain_marks[0] == beats_sent &&
                expected_quats.size() != 0)
            begin
                // hold off until the pipeline has emptied
                in_valid <= 1'b0;
            end
            else if (operand_queue.size() == 0 ||
                     (idle_allowed() && $urandom_range(99) < IDLE_PCT))
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                if (drain_marks.size() != 0 && drain_marks[0] == beats_sent)
                    void'(drain_marks.pop_front());
                nxt      = operand_queue.pop_front();
                cur_beat = nxt;
                in_valid <= 1'b1;
                mode     <= nxt.op;
                q_x      <= nxt.q[0];
                q_y      <= nxt.q[1];
                q_z      <= nxt.q[2];
                q_w      <= nxt.q[3];
                p_x      <= nxt.p[0];
                p_y      <= nxt.p[1];
                p_z      <= nxt.p[2];
                p_w      <= nxt.p[3];
            end
        end
    end

    // output monitor: compares each beat against the oldest prediction
    always @(posedge clk)
    begin
        quat_result_t want;
        comp_t        got [4];
        int           i;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{r_x, r_y, r_z, r_w};
                if (expected_quats.size() == 0)
                begin
                    $display("%0t: unexpected result beat r=(%0d %0d %0d %0d) clipped=%0b",
                             $time, got[0], got[1], got[2], got[3], clipped);
                    errors++;
                end
                else
                begin
                    want = expected_quats.pop_front();
                    for (i = 0; i < 4; i++)
                    begin
                        if (got[i] !== want.r[i])
                        begin
                            $display("%0t: r_%s expected %0d got %0d",
                                     $time, axis[i], want.r[i], got[i]);
                            errors++;
                        end
                    end
                    if (clipped !== want.clip)
                    begin
                        $display("%0t: clipped expected %0b got %0b",
                                 $time, want.clip, clipped);
                        errors++;
                    end
                    if (want.clip)
                        n_saturated++;
                end
            end
            out_ready <= !(idle_allowed() && $urandom_range(99) < IDLE_PCT);
        end
    end

    // stimulus and end of run
    initial
    begin
        item_t it;
        int    n;
        int    i;

        // zeros and identity rotation
        push_item(OP_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0);
        push_item(OP_PRODUCT, 0, 0, 0, 16384, 1000, -2000, 3000, -4000);
        push_item(OP_ROTATE, 0, 0, 0, 16384, 1000, -2000, 3000, -4000);
        // field extremes, with saturation of the intermediate and the final sums
        push_item(OP_PRODUCT, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        push_item(OP_ROTATE, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        push_item(OP_PRODUCT, -32768, -32768, -32768, -32768,
                  -32768, -32768, -32768, -32768);
        push_item(OP_ROTATE, -32768, -32768, -32768, -32768,
                  -32768, -32768, -32768, -32768);
        push_item(OP_PRODUCT, 32767, 32767, 32767, 32767,
                  -32768, -32768, -32768, -32768);
        push_item(OP_PRODUCT, 32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767);
        push_item(OP_ROTATE, 32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767);
        // conjugate of the most negative component
        push_item(OP_ROTATE, -32768, -32768, -32768, 0, 16384, 16384, 16384, 0);
        push_item(OP_ROTATE, -32768, 0, 0, 0, 1, 2, 3, 4);
        // rounding exactly at and around one half, both signs
        push_item(OP_PRODUCT, 0, 0, 0, 1, 0, 0, 0, -8192);
        push_item(OP_PRODUCT, 0, 0, 0, 1, 0, 0, 0, -8193);
        push_item(OP_PRODUCT, 0, 0, 0, 1, 0, 0, 0, 8192);
        push_item(OP_PRODUCT, 0, 0, 0, 1, 0, 0, 0, 8191);
        push_item(OP_PRODUCT, 0, 0, 0, -1, 8192, 8192, 8192, 8192);
        push_item(OP_ROTATE, 0, 0, 0, -1, 8192, -8192, 8193, -8193);
        // quarter turn about z, rotation of a non-pure operand
        push_item(OP_ROTATE, 0, 0, 11585, 11585, 16384, 0, 0, 0);
        push_item(OP_ROTATE, 8192, 8192, 8192, 8192, 100, -200, 300, 16384);
        // intermediate saturates, final may not
        push_item(OP_ROTATE, 0, 0, 0, -32768, 20000, -20000, 20000, 20000);
        push_item(OP_ROTATE, 1, -1, 0, 32767, 32767, -32768, 1, 0);

        // pause once after the directed beats and once mid-way through the random ones
        drain_marks.push_back(operand_queue.size());
        drain_marks.push_back(operand_queue.size() + RAND_ITEMS / 2);

        for (n = 0; n < RAND_ITEMS; n++)
        begin
            it.op = op_t'($urandom_range(1));
            for (i = 0; i < 4; i++)
            begin
                it.q[i] = pick_comp();
                it.p[i] = pick_comp();
            end
            operand_queue.push_back(it);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (operand_queue.size() != 0 || in_valid || expected_quats.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d product and %0d rotate beats, %0d of them saturating",
                 n_products, n_rotations, n_saturated);
        if (errors == 0)
            $display("quaternion_product_rotate_unit test passed");
        else
            $display("quaternion_product_rotate_unit test failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_400_000;
        $display("timeout with %0d results outstanding", expected_quats.size());
        $display("quaternion_product_rotate_unit test failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/qpr_pkg.sv
rtl/qpr_front.sv
rtl/qpr_ham.sv
rtl/qpr_back.sv
rtl/quaternion_product_rotate_unit.sv
verif/tb_top.sv
